// File: design/mpwm_pkg.sv
// Shared types and constants for the multi-pattern wait matcher.
package mpwm_pkg;

    localparam int unsigned OP_W    = 3;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TICKS_W = 16;

    // Idle timeout used when a start transaction carries zero ticks.
    localparam logic [TICKS_W-1:0] DEFAULT_TIMEOUT = TICKS_W'(40);

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_BYTE = 3'd0,
        OP_SET_LEN    = 3'd1,
        OP_START      = 3'd2,
        OP_RX_BYTE    = 3'd3,
        OP_TICK       = 3'd4
    } op_code_t;

    localparam logic EV_MATCH   = 1'b0;
    localparam logic EV_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   position;
        logic [BYTE_W-1:0]  value;
        logic [TICKS_W-1:0] timeout_ticks;
    } in_item_t;

    typedef struct packed {
        logic              event_res;
        logic [SLOT_W-1:0] match_slot;
    } out_item_t;

    // Per-slot command from the control logic, already qualified.
    typedef struct packed {
        logic              byte_we;
        logic              len_we;
        logic              step;
        logic              clear;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } slot_cmd_t;

endpackage

// File: design/mpwm_slot.sv
// One pattern slot: pattern byte store, length, match progress and compare.
module mpwm_slot #(
    parameter int unsigned MAX_LEN = 20
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mpwm_pkg::slot_cmd_t cmd,
    output logic               done
);
    import mpwm_pkg::*;

    localparam int unsigned LW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [BYTE_W-1:0] mem [MAX_LEN];
    logic [BYTE_W-1:0] exp_reg;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_next;
    logic [LW-1:0]     progress_reg;
    logic [LW-1:0]     progress_next;
    logic [LW-1:0]     progress_inc;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              hit;

    assign progress_inc = progress_reg + LW'(1);
    assign hit  = (len_reg != '0) && (progress_reg < len_reg) && (exp_reg == cmd.data);
    assign done = hit && (progress_inc == len_reg);

    always_comb
    begin
        len_next      = len_reg;
        progress_next = progress_reg;
        if (cmd.len_we)
        begin
            len_next      = (32'(cmd.data) > MAX_LEN) ? LW'(MAX_LEN) : LW'(cmd.data);
            progress_next = '0;
        end
        else if (cmd.clear)
        begin
            progress_next = '0;
        end
        else if (cmd.step)
        begin
            progress_next = hit ? progress_inc : '0;
        end
    end

    // Progress stays below the slot length, so the low bits address the store.
    assign rd_addr = progress_next[AW-1:0];
    assign wr_addr = AW'(cmd.pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            progress_reg <= '0;
        end
        else
        begin
            len_reg      <= len_next;
            progress_reg <= progress_next;
        end
    end

    // The expected byte is prefetched for the next received byte; a write to
    // the same position in this cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (cmd.byte_we)
        begin
            mem[wr_addr] <= cmd.data;
        end
        if (cmd.byte_we && (wr_addr == rd_addr))
        begin
            exp_reg <= cmd.data;
        end
        else
        begin
            exp_reg <= mem[rd_addr];
        end
    end

endmodule

// File: design/multi_pattern_wait_matcher_unit.sv
// Top level of the multi-pattern wait matcher: input stage, timer, arming and result stage.
//
// Usage:
// The item channel (item_valid, item_ready, item) carries one transaction per
// command: write a pattern byte, set a pattern length, start a wait, deliver a
// received byte, or signal a timer tick. The result channel (result_valid,
// result_ready, result) carries at most one transaction per command: a match
// with the lowest completed slot, or an idle timeout with slot zero.
// A command is captured in the input register when accepted, evaluated from
// there; any result is held in the result register. Throughput is
// one command per cycle unless the receiver stalls; it is set by the single
// evaluation stage, where every slot compares its prefetched expected byte in
// parallel and the per-slot byte stores are read one address per cycle.
// When the receiver stalls, a pending result holds in the result register and
// the evaluation stage waits, while the input register still holds one more
// command; item_ready drops only when both are full.
// Reset (rst_n, asynchronous, active low) clears all lengths and progress,
// disarms the matcher and loads the default timeout of 40 ticks. Pattern
// bytes are not cleared and must be written before they are compared.
module multi_pattern_wait_matcher_unit #(
    parameter int unsigned NUM_PATTERNS = 9,
    parameter int unsigned MAX_LEN      = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  mpwm_pkg::in_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output mpwm_pkg::out_item_t  result
);
    import mpwm_pkg::*;

    // Input stage.
    logic      in_vld_reg;
    in_item_t  in_reg;
    logic      fire;

    // Matcher control state.
    logic                armed_reg;
    logic                armed_next;
    logic [TICKS_W-1:0]  reload_reg;
    logic [TICKS_W-1:0]  reload_next;
    logic [TICKS_W-1:0]  idle_reg;
    logic [TICKS_W-1:0]  idle_next;
    logic [TICKS_W-1:0]  idle_dec;

    // Result stage.
    logic       res_vld_reg;
    logic       res_vld_next;
    out_item_t  res_reg;

    // Decoded command of the evaluated transaction.
    logic       do_start;
    logic       do_rx;
    logic       do_step;
    logic       do_tick;
    logic       timed_out;
    logic       matched;
    logic       clear_all;
    logic [SLOT_W-1:0] first_slot;

    slot_cmd_t                slot_cmd [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0]  slot_done;

    // The evaluation stage advances only when the result register is free or
    // is being emptied in the same cycle, so no result can be overwritten.
    assign fire       = in_vld_reg && (!res_vld_reg || result_ready);
    assign item_ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_reg <= item;
        end
    end

    assign do_start = fire && (in_reg.op == OP_START);
    assign do_rx    = fire && (in_reg.op == OP_RX_BYTE) && armed_reg;
    // Null bytes restart the idle timer but are never compared.
    assign do_step  = do_rx && (in_reg.value != '0);
    assign do_tick  = fire && (in_reg.op == OP_TICK) && armed_reg;

    assign idle_dec  = (idle_reg != '0) ? (idle_reg - TICKS_W'(1)) : '0;
    assign timed_out = do_tick && (idle_dec == '0);
    assign matched   = do_step && (slot_done != '0);
    assign clear_all = do_start || matched || timed_out;

    // Lowest completed slot wins.
    always_comb
    begin
        first_slot = '0;
        for (int i = NUM_PATTERNS - 1; i >= 0; i--)
        begin
            if (slot_done[i])
            begin
                first_slot = SLOT_W'(i);
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_PATTERNS; g++)
        begin : gen_slot
            always_comb
            begin
                slot_cmd[g].byte_we = fire && (in_reg.op == OP_WRITE_BYTE)
                                      && (in_reg.slot == SLOT_W'(g))
                                      && (32'(in_reg.position) < MAX_LEN);
                slot_cmd[g].len_we  = fire && (in_reg.op == OP_SET_LEN)
                                      && (in_reg.slot == SLOT_W'(g));
                slot_cmd[g].step    = do_step;
                slot_cmd[g].clear   = clear_all;
                slot_cmd[g].pos     = in_reg.position;
                slot_cmd[g].data    = in_reg.value;
            end

            mpwm_slot #(
                .MAX_LEN (MAX_LEN)
            ) u_slot (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (slot_cmd[g]),
                .done  (slot_done[g])
            );
        end
    endgenerate

    // Arming and the idle timer.
    always_comb
    begin
        armed_next  = armed_reg;
        reload_next = reload_reg;
        idle_next   = idle_reg;
        if (do_start)
        begin
            reload_next = (in_reg.timeout_ticks != '0) ? in_reg.timeout_ticks
                                                       : DEFAULT_TIMEOUT;
            idle_next   = reload_next;
            armed_next  = 1'b1;
        end
        else if (do_rx)
        begin
            idle_next = reload_reg;
        end
        else if (do_tick)
        begin
            idle_next = idle_dec;
        end
        if (matched || timed_out)
        begin
            armed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            reload_reg <= DEFAULT_TIMEOUT;
            idle_reg   <= '0;
        end
        else
        begin
            armed_reg  <= armed_next;
            reload_reg <= reload_next;
            idle_reg   <= idle_next;
        end
    end

    // Result register.
    always_comb
    begin
        res_vld_next = res_vld_reg;
        if (matched || timed_out)
        begin
            res_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (matched)
        begin
            res_reg.event_res  <= EV_MATCH;
            res_reg.match_slot <= first_slot;
        end
        else if (timed_out)
        begin
            res_reg.event_res  <= EV_TIMEOUT;
            res_reg.match_slot <= '0;
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    // A held command is kept until the evaluation stage takes it.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !fire |=> in_vld_reg)
        else $error("held command lost from the input register");

    // A stalled result is never dropped.
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !result_ready |=> res_vld_reg)
        else $error("pending result dropped while the receiver stalls");

    // Every reported event leaves the matcher disarmed.
    a_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        matched || timed_out |=> !armed_reg)
        else $error("matcher still armed after reporting an event");

    // A match names a slot that exists.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && (res_reg.event_res == EV_MATCH)
        |-> (32'(res_reg.match_slot) < NUM_PATTERNS))
        else $error("match reported for a slot beyond the pattern count");

endmodule
